// ===== rtl/core/rstd_pkg.sv =====
// Shared types and constants for the running statistics threshold detector.
package rsd_pkg;
  localparam int FRAC_BITS = 16;
  localparam int SQ_WIDTH = 56;
  localparam int VAR_WIDTH = 40;
  localparam int THR_WIDTH = 48;
  localparam int MEAN_WIDTH = 28;
  localparam int SIGMA_WIDTH = 16;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 48'd19661;
  localparam logic [SIGMA_WIDTH-1:0] SIGMA_RESET = 16'd256;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_RECOMPUTE = 2'd2,
    OP_NONE = 2'd3
  } op_t;
endpackage

// ===== rtl/core/running_stats_threshold_detector.sv =====
// Top level of the running statistics threshold detector.
// A sample item runs two serial divider passes (mean step, then variance) plus control;
// unused items run the variance division only; recompute items then update the threshold.
// Clear items, and unused or recompute items with a zero count, skip the divider.
// One item at a time: the next item is accepted only once its result is taken and the block is idle.
// Synchronous reset clears statistics, sets threshold to 0.3 and sigma to 1.0.
module running_stats_threshold_detector #(
  parameter int COUNT_WIDTH = 16,
  parameter int SAMPLE_WIDTH = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [11:0] sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        quake,
  output logic [27:0] mean,
  output logic [39:0] variance,
  output logic [47:0] threshold,
  output logic [15:0] sample_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  localparam int SQW = rsd_pkg::SQ_WIDTH;
  localparam int MW = SAMPLE_WIDTH + rsd_pkg::FRAC_BITS;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_MDIV, S_SQ, S_VSTART, S_VDIV, S_MUL, S_OUT
  } state_t;

  state_t state;
  logic [MW-1:0]          mean_acc;
  logic [SQW-1:0]         sq_dev_sum;
  logic [COUNT_WIDTH-1:0] count_reg;
  logic [47:0]            threshold_reg;
  logic [15:0]            sigma;
  logic [1:0]             op;
  logic [MW-1:0]          val;
  logic                   up;
  logic [MW-1:0]          d;
  logic                   qk;
  logic [39:0]            var_reg;
  logic [56:0]            prod;

  logic             div_start;
  logic [SQW-1:0]   div_num;
  logic             div_done;
  logic [SQW-1:0]   div_q;

  rsd_divider #(.NUM_WIDTH(SQW), .DEN_WIDTH(COUNT_WIDTH)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_num),
    .denom(count_reg), .done(div_done), .quot(div_q)
  );

  logic [MW-1:0] mstep;
  logic [MW-1:0] mean_new;
  logic [MW-1:0] d2;
  logic [2*MW-1:0] dd;
  logic [SQW:0] sq_sum;
  logic [39:0] vsat;
  logic [SAMPLE_WIDTH-1:0] smp;
  logic [MW-1:0] sval;
  logic sval_up;
  logic [MW-1:0] sdiff;

  assign smp = SAMPLE_WIDTH'(sample);
  assign sval = {smp, {rsd_pkg::FRAC_BITS{1'b0}}};
  assign sval_up = sval >= mean_acc;
  assign sdiff = sval_up ? sval - mean_acc : mean_acc - sval;

  assign mstep = div_q[MW-1:0];
  assign mean_new = up ? mean_acc + mstep : mean_acc - mstep;
  assign d2 = up ? val - mean_acc : mean_acc - val;
  assign dd = d * d2;
  assign sq_sum = {1'b0, sq_dev_sum} + (SQW+1)'(dd >> rsd_pkg::FRAC_BITS);
  assign vsat = (|div_q[SQW-1:40]) ? '1 : div_q[39:0];

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mean_acc <= '0;
      sq_dev_sum <= '0;
      count_reg <= '0;
      threshold_reg <= rsd_pkg::THR_RESET;
      sigma <= rsd_pkg::SIGMA_RESET;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      var_reg <= '0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) sigma <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= operation;
            qk <= 1'b0;
            case (operation)
              rsd_pkg::OP_SAMPLE: begin
                val <= sval;
                up <= sval_up;
                d <= sdiff;
                qk <= 48'(sval) > threshold_reg;
                if (count_reg != CMAX) count_reg <= count_reg + 1'b1;
                div_num <= SQW'(sdiff);
                div_start <= 1'b1;
                state <= S_MDIV;
              end
              rsd_pkg::OP_CLEAR: begin
                mean_acc <= '0;
                sq_dev_sum <= '0;
                count_reg <= '0;
                state <= S_VSTART;
              end
              default: state <= S_VSTART;
            endcase
          end
        end
        S_MDIV: begin
          if (div_done) begin
            mean_acc <= mean_new;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq_dev_sum <= sq_sum[SQW] ? '1 : sq_sum[SQW-1:0];
          state <= S_VSTART;
        end
        S_VSTART: begin
          if (count_reg == '0) begin
            var_reg <= '0;
            state <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            div_num <= sq_dev_sum;
            div_start <= 1'b1;
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (div_done) begin
            var_reg <= vsat;
            prod <= 57'(vsat * sigma);
            if (op == rsd_pkg::OP_RECOMPUTE) begin
              state <= S_MUL;
            end else begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end
          end
        end
        S_MUL: begin
          if ((|prod[56:56]) ||
              (({2'b0, prod[55:8]} + 50'(mean_acc)) > 50'({48{1'b1}}))) begin
            threshold_reg <= '1;
          end else begin
            threshold_reg <= prod[55:8] + 48'(mean_acc);
          end
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign quake = qk;
  assign mean = 28'(mean_acc);
  assign variance = var_reg;
  assign threshold = threshold_reg;
  assign sample_count = 16'(count_reg);
endmodule

// ===== rtl/core/rsd_divider.sv =====
// Restoring serial divider that produces one quotient bit per cycle.
module rsd_divider #(
  parameter int NUM_WIDTH = 56,
  parameter int DEN_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] numer,
  input  logic [DEN_WIDTH-1:0] denom,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] quot
);
  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [DEN_WIDTH:0]   rem;
  logic [NUM_WIDTH-1:0] num;
  logic [DEN_WIDTH-1:0] den;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic [DEN_WIDTH:0]   trial;
  logic [DEN_WIDTH:0]   diff;

  assign trial = {rem[DEN_WIDTH-1:0], num[NUM_WIDTH-1]};
  assign diff = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        num <= numer;
        den <= denom;
        quot <= '0;
        cnt <= CW'(NUM_WIDTH);
      end else if (busy) begin
        num <= {num[NUM_WIDTH-2:0], 1'b0};
        if (!diff[DEN_WIDTH]) begin
          rem <= diff;
          quot <= {quot[NUM_WIDTH-2:0], 1'b1};
        end else begin
          rem <= trial;
          quot <= {quot[NUM_WIDTH-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
